### rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int CELL_ADDR_W = 12;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  DEFAULT_ATTR = 8'h0F;
  localparam logic [15:0] BLANK_CELL   = {DEFAULT_ATTR, SPACE_CODE};

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    K_WRITE,
    K_NEWLINE,
    K_MOVE,
    K_CLEAR,
    K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             ch;
    logic [7:0]             attr;
    logic [6:0]             tcol;
    logic [4:0]             trow;
    logic [CELL_ADDR_W-1:0] addr;
    logic                   in_range;
  } cmd_t;

endpackage

### rtl/core/text_console_writer.sv
// A write, newline, move or out-of-range read passes the front register, the command queue and
// the output register; an in-range read also passes the memory read register and ST_READ. A short
// item leaves the back end every cycle while out_tready is high. A scroll holds the back end while
// it copies rows up through the cell memory with one read and one write a cycle, then refills the
// bottom row; a clear holds it while it refills every cell. After reset the cell memory is swept
// to blank, one cell per cycle, and in_tready stays low until the sweep ends; the cursor resets to the top left.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code, fg_color, bg_color, target_col, target_row
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // col_now, row_now, cell_char, cell_attr
  output logic [1:0]  out_tuser   // scrolled, rejected
);

  tcw_pkg::cmd_t front_cmd;
  tcw_pkg::cmd_t back_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          back_valid;
  logic          back_ready;
  logic          init_busy;
  logic [6:0]    col_now;
  logic [4:0]    row_now;
  logic [7:0]    cell_char;
  logic [7:0]    cell_attr;
  logic          scrolled;
  logic          rejected;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (init_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  tcw_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .col_now   (col_now),
    .row_now   (row_now),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .scrolled  (scrolled),
    .rejected  (rejected)
  );

  assign out_tdata = {4'h0, cell_attr, cell_char, row_now, col_now};
  assign out_tuser = {rejected, scrolled};

  a_init_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_tready)
    else $error("input taken during the reset sweep");

  a_row_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, row_now} < 6'(ROWS)) && ({1'b0, col_now} < 8'(COLS)))
    else $error("cursor outside the grid");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(scrolled && rejected))
    else $error("result both scrolled and rejected");

  a_scroll_cursor : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && scrolled) |-> (col_now == '0) && (row_now == 5'(ROWS - 1)))
    else $error("scroll left the cursor off the bottom row start");

endmodule

### rtl/core/tcw_front.sv
module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hold,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tcw_pkg::cmd_t cmd
);

  logic          fv_r;
  logic          fv_nxt;
  tcw_pkg::cmd_t cmd_r;
  tcw_pkg::cmd_t cmd_nxt;

  logic [7:0] f_ch;
  logic [3:0] f_fg;
  logic [3:0] f_bg;
  logic [6:0] f_col;
  logic [4:0] f_row;

  assign f_ch  = in_tdata[7:0];
  assign f_fg  = in_tdata[11:8];
  assign f_bg  = in_tdata[15:12];
  assign f_col = in_tdata[22:16];
  assign f_row = in_tdata[27:23];

  assign in_tready = !hold && (!fv_r || cmd_ready);
  assign cmd_valid = fv_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt          = cmd_r;
    cmd_nxt.ch       = f_ch;
    cmd_nxt.attr     = {f_bg, f_fg};
    cmd_nxt.tcol     = f_col;
    cmd_nxt.trow     = f_row;
    cmd_nxt.addr     = tcw_pkg::CELL_ADDR_W'(f_row) * tcw_pkg::CELL_ADDR_W'(COLS)
                       + tcw_pkg::CELL_ADDR_W'(f_col);
    cmd_nxt.in_range = (32'(f_col) < COLS) && (32'(f_row) < ROWS);
    unique case (tcw_pkg::mode_t'(in_tuser))
      tcw_pkg::MODE_WRITE: begin
        cmd_nxt.kind = (f_ch == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::K_NEWLINE
                                                       : tcw_pkg::K_WRITE;
      end
      tcw_pkg::MODE_MOVE: begin
        cmd_nxt.kind = tcw_pkg::K_MOVE;
      end
      tcw_pkg::MODE_CLEAR: begin
        cmd_nxt.kind = tcw_pkg::K_CLEAR;
        cmd_nxt.attr = {f_bg, 4'h0};
      end
      tcw_pkg::MODE_READ: begin
        cmd_nxt.kind = tcw_pkg::K_READ;
      end
      default: begin
        cmd_nxt.kind = tcw_pkg::K_READ;
      end
    endcase
  end

  always_comb begin
    fv_nxt = fv_r;
    if (in_tvalid && in_tready) begin
      fv_nxt = 1'b1;
    end else if (cmd_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### rtl/core/tcw_cmd_fifo.sv
module tcw_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tcw_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tcw_pkg::cmd_t rd_data
);

  localparam int CNT_W = $clog2(tcw_pkg::CMDQ_DEPTH + 1);

  tcw_pkg::cmd_t                   q_mem [tcw_pkg::CMDQ_DEPTH];
  logic [tcw_pkg::CMDQ_PTR_W-1:0] wp_r;
  logic [tcw_pkg::CMDQ_PTR_W-1:0] wp_nxt;
  logic [tcw_pkg::CMDQ_PTR_W-1:0] rp_r;
  logic [tcw_pkg::CMDQ_PTR_W-1:0] rp_nxt;
  logic [CNT_W-1:0]               cnt_r;
  logic [CNT_W-1:0]               cnt_nxt;
  logic                           push;
  logic                           pop;

  assign wr_ready = (cnt_r != CNT_W'(tcw_pkg::CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = q_mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= wr_data;
    end
  end

endmodule

### rtl/core/tcw_back.sv
module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tcw_pkg::cmd_t cmd,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [6:0]    col_now,
  output logic [4:0]    row_now,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_attr,
  output logic          scrolled,
  output logic          rejected
);

  localparam int CELL_COUNT = COLS * ROWS;
  localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int LAST_BASE  = (ROWS - 1) * COLS;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] ptr_r;
  logic [15:0]      fill_val_r;
  logic             emit_r;
  logic             cp_valid_r;
  logic [IDX_W-1:0] cp_dst_r;
  logic [6:0]       col_r;
  logic [4:0]       row_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] base_r;

  logic             out_valid_r;
  logic [6:0]       out_col_r;
  logic [4:0]       out_row_r;
  logic [7:0]       out_char_r;
  logic [7:0]       out_attr_r;
  logic             out_scr_r;
  logic             out_rej_r;

  logic [15:0]      mem [CELL_COUNT];
  logic [15:0]      rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic             pop;
  logic [7:0]       col_p1;
  logic [5:0]       row_p1;
  logic             wrap;
  logic             scroll_now;

  assign pop       = (state_r == ST_IDLE) && cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = pop;
  assign init_busy = (state_r == ST_FILL) && !emit_r;

  assign out_valid = out_valid_r;
  assign col_now   = out_col_r;
  assign row_now   = out_row_r;
  assign cell_char = out_char_r;
  assign cell_attr = out_attr_r;
  assign scrolled  = out_scr_r;
  assign rejected  = out_rej_r;

  assign col_p1     = {1'b0, col_r} + 8'd1;
  assign row_p1     = {1'b0, row_r} + 6'd1;
  assign wrap       = (cmd.kind == tcw_pkg::K_NEWLINE) || (col_p1 == 8'(COLS));
  assign scroll_now = wrap && (row_p1 == 6'(ROWS));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r[IDX_W-1:0];
    mem_wdata = fill_val_r;
    mem_raddr = cmd.addr[IDX_W-1:0];
    unique case (state_r)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = pop && (cmd.kind == tcw_pkg::K_WRITE);
        mem_waddr = cur_r;
        mem_wdata = {cmd.attr, cmd.ch};
      end
      ST_SCROLL: begin
        mem_we    = cp_valid_r;
        mem_waddr = cp_dst_r;
        mem_wdata = rd_data_r;
        mem_raddr = ptr_r[IDX_W-1:0];
      end
      ST_READ: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ptr_r       <= '0;
      fill_val_r  <= tcw_pkg::BLANK_CELL;
      emit_r      <= 1'b0;
      cp_valid_r  <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      cur_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_FILL: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
            state_r <= ST_IDLE;
            if (emit_r) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_IDLE: begin
          if (pop) begin
            out_char_r <= '0;
            out_attr_r <= '0;
            out_scr_r  <= 1'b0;
            out_rej_r  <= 1'b0;
            out_col_r  <= col_r;
            out_row_r  <= row_r;
            unique case (cmd.kind)
              tcw_pkg::K_WRITE, tcw_pkg::K_NEWLINE: begin
                if (scroll_now) begin
                  col_r      <= '0;
                  row_r      <= 5'(ROWS - 1);
                  cur_r      <= IDX_W'(LAST_BASE);
                  base_r     <= IDX_W'(LAST_BASE);
                  out_col_r  <= '0;
                  out_row_r  <= 5'(ROWS - 1);
                  out_scr_r  <= 1'b1;
                  ptr_r      <= CNT_W'(COLS);
                  cp_valid_r <= 1'b0;
                  state_r    <= ST_SCROLL;
                end else if (wrap) begin
                  col_r       <= '0;
                  row_r       <= row_p1[4:0];
                  cur_r       <= base_r + IDX_W'(COLS);
                  base_r      <= base_r + IDX_W'(COLS);
                  out_col_r   <= '0;
                  out_row_r   <= row_p1[4:0];
                  out_valid_r <= 1'b1;
                end else begin
                  col_r       <= col_p1[6:0];
                  cur_r       <= cur_r + 1'b1;
                  out_col_r   <= col_p1[6:0];
                  out_valid_r <= 1'b1;
                end
              end
              tcw_pkg::K_MOVE: begin
                if (cmd.in_range) begin
                  col_r     <= cmd.tcol;
                  row_r     <= cmd.trow;
                  cur_r     <= cmd.addr[IDX_W-1:0];
                  base_r    <= cmd.addr[IDX_W-1:0] - IDX_W'(cmd.tcol);
                  out_col_r <= cmd.tcol;
                  out_row_r <= cmd.trow;
                end else begin
                  out_rej_r <= 1'b1;
                end
                out_valid_r <= 1'b1;
              end
              tcw_pkg::K_CLEAR: begin
                col_r      <= '0;
                row_r      <= '0;
                cur_r      <= '0;
                base_r     <= '0;
                out_col_r  <= '0;
                out_row_r  <= '0;
                ptr_r      <= '0;
                fill_val_r <= {cmd.attr, tcw_pkg::SPACE_CODE};
                emit_r     <= 1'b1;
                state_r    <= ST_FILL;
              end
              tcw_pkg::K_READ: begin
                if (cmd.in_range) begin
                  state_r <= ST_READ;
                end else begin
                  out_rej_r   <= 1'b1;
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_rej_r   <= 1'b1;
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          out_char_r  <= rd_data_r[7:0];
          out_attr_r  <= rd_data_r[15:8];
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (ptr_r == CNT_W'(CELL_COUNT)) begin
            cp_valid_r <= 1'b0;
            ptr_r      <= CNT_W'(LAST_BASE);
            fill_val_r <= tcw_pkg::BLANK_CELL;
            emit_r     <= 1'b1;
            state_r    <= ST_FILL;
          end else begin
            cp_valid_r <= 1'b1;
            cp_dst_r   <= IDX_W'(ptr_r - CNT_W'(COLS));
            ptr_r      <= ptr_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
